FILE: rtl/look_at_view_matrix_unit_defines.svh
// Assertion macros for the look-at view matrix unit.
`ifndef LOOK_AT_VIEW_MATRIX_UNIT_DEFINES_SVH
`define LOOK_AT_VIEW_MATRIX_UNIT_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, disabled in reset.
`define LAV_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled in reset.
`define LAV_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LAV_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define LAV_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

FILE: rtl/lav_pkg.sv
// Types and constants shared by the look-at view matrix unit.
`default_nettype none
package lav_pkg;

   localparam int FRAC_BITS = 16;

   // internal widths, several follow from the fraction width
   localparam int D_W     = 33;              // eye minus target
   localparam int NORM_W  = FRAC_BITS + 2;   // unit axis component
   localparam int VEC_W   = FRAC_BITS + 34;  // raw vector into the normalizer
   localparam int G_W     = FRAC_BITS + 3;   // camera up component
   localparam int OFS_W   = FRAC_BITS + 37;  // unrounded offset
   localparam int UNIT_MSB = 29;             // normalized magnitude lies in [2^29, 2^30)
   localparam int UNIT_W  = 30;
   localparam int SUM_W   = 64;
   localparam int LEN_W   = 31;
   localparam int DIV_W   = FRAC_BITS + 32;
   localparam int QUO_W   = FRAC_BITS + 1;

   // queue between front and back
   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   typedef logic signed [31:0]       fix_type;
   typedef logic signed [D_W-1:0]    dlt_type;
   typedef logic signed [NORM_W-1:0] nrm_type;
   typedef logic signed [VEC_W-1:0]  vec_type;

   typedef struct packed {
      fix_type eye_x;
      fix_type eye_y;
      fix_type eye_z;
      fix_type target_x;
      fix_type target_y;
      fix_type target_z;
      fix_type world_up_x;
      fix_type world_up_y;
      fix_type world_up_z;
   } lav_req_type;

   typedef struct packed {
      fix_type right_x;
      fix_type right_y;
      fix_type right_z;
      fix_type right_offset;
      fix_type camera_up_x;
      fix_type camera_up_y;
      fix_type camera_up_z;
      fix_type camera_up_offset;
      fix_type back_x;
      fix_type back_y;
      fix_type back_z;
      fix_type back_offset;
   } lav_rsp_type;

   // item as queued between front and back; index 0 is x
   typedef struct packed {
      fix_type [2:0] eye;
      fix_type [2:0] up;
      dlt_type [2:0] dlt;
   } lav_cmd_type;

   // data that rides along a normalizer
   typedef struct packed {
      fix_type [2:0] eye;
      fix_type [2:0] up;
      nrm_type [2:0] h;
   } lav_side_type;

   typedef struct packed {
      logic              vld;
      logic              full;
      logic [QCNT_W-1:0] count;
   } lav_qstat_type;

endpackage
`default_nettype wire

FILE: rtl/lav_if.sv
// Valid/ready channel interfaces for request and response items.
`default_nettype none
interface lav_req_if import lav_pkg::*; ();
   logic        valid;
   logic        ready;
   lav_req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface lav_rsp_if import lav_pkg::*; ();
   logic        valid;
   logic        ready;
   lav_rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/lav_queue.sv
// Short FIFO between the front stage and the back pipeline.
`default_nettype none
module lav_queue import lav_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_vld,
   output logic          push_rdy,
   input  lav_cmd_type   push_cmd,
   input  logic          pop,
   output lav_qstat_type stat,
   output lav_cmd_type   pop_cmd
);

   lav_cmd_type       mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              do_push, do_pop;

   // handshake and pointers
   always_comb begin
      push_rdy  = (cnt_ff != QCNT_W'(QDEPTH));
      do_push   = push_vld && push_rdy;
      do_pop    = pop && (cnt_ff != '0);
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign pop_cmd    = mem_ff[rd_ptr_ff];
   assign stat.vld   = (cnt_ff != '0);
   assign stat.full  = !push_rdy;
   assign stat.count = cnt_ff;

endmodule
`default_nettype wire

FILE: rtl/lav_front.sv
// Front stage: takes request items and forms the eye-to-target difference.
`default_nettype none
module lav_front import lav_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   lav_req_if.sink     req,
   output logic        push_vld,
   input  logic        push_rdy,
   output lav_cmd_type push_cmd
);

   logic        vld_ff, vld_in;
   lav_cmd_type cmd_ff, cmd_in;
   logic        take;

   // accept while empty or while the held item moves on
   always_comb begin
      req.ready = !vld_ff || push_rdy;
      take      = req.valid && req.ready;
      if (take) begin
         vld_in = 1'b1;
      end else if (push_rdy) begin
         vld_in = 1'b0;
      end else begin
         vld_in = vld_ff;
      end
      cmd_in.eye[0] = req.data.eye_x;
      cmd_in.eye[1] = req.data.eye_y;
      cmd_in.eye[2] = req.data.eye_z;
      cmd_in.up[0]  = req.data.world_up_x;
      cmd_in.up[1]  = req.data.world_up_y;
      cmd_in.up[2]  = req.data.world_up_z;
      cmd_in.dlt[0] = D_W'($signed(req.data.eye_x)) - D_W'($signed(req.data.target_x));
      cmd_in.dlt[1] = D_W'($signed(req.data.eye_y)) - D_W'($signed(req.data.target_y));
      cmd_in.dlt[2] = D_W'($signed(req.data.eye_z)) - D_W'($signed(req.data.target_z));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cmd_ff <= cmd_in;
      end
   end

   assign push_vld = vld_ff;
   assign push_cmd = cmd_ff;

endmodule
`default_nettype wire

FILE: rtl/lav_norm.sv
// Pipelined 3-vector normalizer: scale, squares, bitwise root, restoring divide.
`default_nettype none
module lav_norm import lav_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_vld,
   input  vec_type [2:0]     in_vec,
   input  lav_side_type      in_side,
   output logic              out_vld,
   output nrm_type [2:0]     out_nrm,
   output lav_side_type      out_side
);

   localparam int NGRP  = (VEC_W + 7) / 8;
   localparam int PAD_W = NGRP * 8;
   localparam int PW    = $clog2(PAD_W);
   localparam int NSQ   = 32;
   localparam int NDV   = QUO_W;
   localparam int S_SQ0 = 6;
   localparam int S_DV0 = S_SQ0 + NSQ;
   localparam int S_OUT = S_DV0 + NDV;

   typedef struct packed {
      logic [2:0]   neg;
      logic         zero;
      lav_side_type side;
   } tag_type;

   typedef struct packed {
      logic [SUM_W-1:0] num;
      logic [SUM_W-1:0] res;
   } sq_type;

   typedef struct packed {
      logic [DIV_W-1:0] r;
      logic [QUO_W-1:0] q;
   } dv_type;

   // one step of the bitwise square root
   function automatic sq_type sq_step(input logic [SUM_W-1:0] num,
                                      input logic [SUM_W-1:0] res, input int k);
      logic [SUM_W-1:0] bt;
      sq_type           o;
      bt = SUM_W'(1) << (2 * (NSQ - 1) - 2 * k);
      if (num >= res + bt) begin
         o.num = num - (res + bt);
         o.res = (res >> 1) + bt;
      end else begin
         o.num = num;
         o.res = res >> 1;
      end
      return o;
   endfunction

   // one quotient bit of the restoring divide
   function automatic dv_type dv_step(input logic [DIV_W-1:0] r, input logic [QUO_W-1:0] q,
                                      input logic [LEN_W-1:0] l, input int k);
      logic [DIV_W-1:0] trial;
      dv_type           o;
      trial = DIV_W'(l) << k;
      if (r >= trial) begin
         o.r = r - trial;
         o.q = q | (QUO_W'(1) << k);
      end else begin
         o.r = r;
         o.q = q;
      end
      return o;
   endfunction

   logic                 vld_ff [0:S_OUT];
   tag_type              tag_ff [0:S_OUT];
   tag_type              tag_in;
   logic [VEC_W-1:0]     in_mag [3];
   logic [VEC_W-1:0]     mag_ff [0:2][3];
   logic [PAD_W-1:0]     or_ff;
   logic                 gnz_ff [NGRP];
   logic [2:0]           gpos_ff [NGRP];
   logic                 gnz_in [NGRP];
   logic [2:0]           gpos_in [NGRP];
   logic [PW-1:0]        p_ff, p_in;
   logic [UNIT_W-1:0]    m_in [3];
   logic [UNIT_W-1:0]    m_ff [3:S_DV0-1][3];
   logic [2*UNIT_W-1:0]  sq_ff [3];
   logic [SUM_W-1:0]     num_ff [S_SQ0-1:S_DV0-1];
   logic [SUM_W-1:0]     res_ff [S_SQ0-1:S_DV0-1];
   sq_type               sq_in [S_SQ0:S_DV0-1];
   logic [LEN_W-1:0]     len0;
   logic [DIV_W-1:0]     n0 [3];
   dv_type               dv_in [S_DV0:S_OUT-1][3];
   logic [DIV_W-1:0]     dr_ff [S_DV0:S_OUT-1][3];
   logic [QUO_W-1:0]     dq_ff [S_DV0:S_OUT-1][3];
   logic [LEN_W-1:0]     dl_ff [S_DV0:S_OUT-1];
   nrm_type [2:0]        nrm_ff, nrm_in;

   // sign, zero test and magnitudes at the input
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         tag_in.neg[i] = in_vec[i][VEC_W-1];
         in_mag[i]     = in_vec[i][VEC_W-1] ? VEC_W'(-in_vec[i]) : VEC_W'(in_vec[i]);
      end
      tag_in.zero = (in_vec[0] == '0) && (in_vec[1] == '0) && (in_vec[2] == '0);
      tag_in.side = in_side;
   end

   // leading one of the largest magnitude, found in byte groups
   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         gnz_in[g]  = |or_ff[g*8 +: 8];
         gpos_in[g] = '0;
         for (int b = 0; b < 8; b++) begin
            if (or_ff[g*8 + b]) begin
               gpos_in[g] = 3'(b);
            end
         end
      end
      p_in = '0;
      for (int g = 0; g < NGRP; g++) begin
         if (gnz_ff[g]) begin
            p_in = PW'(g * 8) + PW'(gpos_ff[g]);
         end
      end
   end

   // common scale so the largest lands in [2^29, 2^30)
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (p_ff >= PW'(UNIT_MSB)) begin
            m_in[i] = UNIT_W'(mag_ff[2][i] >> (p_ff - PW'(UNIT_MSB)));
         end else begin
            m_in[i] = UNIT_W'(mag_ff[2][i] << (PW'(UNIT_MSB) - p_ff));
         end
      end
   end

   // root and divide steps
   always_comb begin
      for (int k = 0; k < NSQ; k++) begin
         sq_in[S_SQ0 + k] = sq_step(num_ff[S_SQ0 + k - 1], res_ff[S_SQ0 + k - 1], k);
      end
      len0 = res_ff[S_DV0-1][LEN_W-1:0];
      for (int i = 0; i < 3; i++) begin
         n0[i] = (DIV_W'(m_ff[S_DV0-1][i]) << FRAC_BITS) + DIV_W'(len0 >> 1);
         dv_in[S_DV0][i] = dv_step(n0[i], '0, len0, FRAC_BITS);
         for (int j = 1; j < NDV; j++) begin
            dv_in[S_DV0 + j][i] = dv_step(dr_ff[S_DV0 + j - 1][i], dq_ff[S_DV0 + j - 1][i],
                                          dl_ff[S_DV0 + j - 1], FRAC_BITS - j);
         end
      end
   end

   // sign applied, zero vector forced to zero
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (tag_ff[S_OUT-1].zero) begin
            nrm_in[i] = '0;
         end else if (tag_ff[S_OUT-1].neg[i]) begin
            nrm_in[i] = -NORM_W'(dq_ff[S_OUT-1][i]);
         end else begin
            nrm_in[i] = NORM_W'(dq_ff[S_OUT-1][i]);
         end
      end
   end

   // valid line
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= S_OUT; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= in_vld;
         for (int s = 1; s <= S_OUT; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   // data stages
   always_ff @(posedge clock) begin
      if (adv) begin
         tag_ff[0] <= tag_in;
         for (int s = 1; s <= S_OUT; s++) begin
            tag_ff[s] <= tag_ff[s-1];
         end
         or_ff <= PAD_W'(in_mag[0] | in_mag[1] | in_mag[2]);
         for (int i = 0; i < 3; i++) begin
            mag_ff[0][i] <= in_mag[i];
            mag_ff[1][i] <= mag_ff[0][i];
            mag_ff[2][i] <= mag_ff[1][i];
            m_ff[3][i]   <= m_in[i];
            for (int s = 4; s < S_DV0; s++) begin
               m_ff[s][i] <= m_ff[s-1][i];
            end
            sq_ff[i] <= m_ff[3][i] * m_ff[3][i];
         end
         for (int g = 0; g < NGRP; g++) begin
            gnz_ff[g]  <= gnz_in[g];
            gpos_ff[g] <= gpos_in[g];
         end
         p_ff <= p_in;
         num_ff[S_SQ0-1] <= SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);
         res_ff[S_SQ0-1] <= '0;
         for (int s = S_SQ0; s < S_DV0; s++) begin
            num_ff[s] <= sq_in[s].num;
            res_ff[s] <= sq_in[s].res;
         end
         dl_ff[S_DV0] <= len0;
         for (int s = S_DV0 + 1; s < S_OUT; s++) begin
            dl_ff[s] <= dl_ff[s-1];
         end
         for (int s = S_DV0; s < S_OUT; s++) begin
            for (int i = 0; i < 3; i++) begin
               dr_ff[s][i] <= dv_in[s][i].r;
               dq_ff[s][i] <= dv_in[s][i].q;
            end
         end
         nrm_ff <= nrm_in;
      end
   end

   assign out_vld  = vld_ff[S_OUT];
   assign out_nrm  = nrm_ff;
   assign out_side = tag_ff[S_OUT].side;

endmodule
`default_nettype wire

FILE: rtl/lav_back.sv
// Back pipeline: back axis, cross product, right axis, camera up and offsets.
`default_nettype none
module lav_back import lav_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_vld,
   input  lav_cmd_type q_cmd,
   output logic        pop,
   lav_rsp_if.source   rsp
);

   localparam int XP_W = 32 + NORM_W;
   localparam int GP_W = 2 * NORM_W;
   localparam int GD_W = 2 * NORM_W + 1;
   localparam int OP_W = 32 + G_W;
   localparam logic signed [GD_W-1:0] G_RND = GD_W'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [OFS_W-1:0] O_RND = OFS_W'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [OFS_W-1:0] SAT_MAX = OFS_W'(2147483647);
   localparam logic signed [OFS_W-1:0] SAT_MIN = ~SAT_MAX;

   typedef logic signed [G_W-1:0] gax_type;

   logic          adv;
   vec_type [2:0] n1_vec;
   lav_side_type  n1_side_in;
   logic          n1_vld;
   nrm_type [2:0] n1_h;
   lav_side_type  n1_side;
   logic          n2_vld;
   nrm_type [2:0] n2_f;
   lav_side_type  n2_side;

   logic                    xv_ff, cv_ff, g1v_ff, g2v_ff, o1v_ff, o2v_ff, o3v_ff;
   logic signed [XP_W-1:0]  xp_ff [6];
   lav_side_type            xs_ff, cs_ff;
   vec_type [2:0]           cv_vec_ff;
   logic signed [GP_W-1:0]  gp_ff [6];
   nrm_type [2:0]           g1f_ff, g2f_ff, o1f_ff, o2f_ff;
   lav_side_type            g1s_ff, g2s_ff;
   logic signed [GD_W-1:0]  gd_in [3];
   gax_type [2:0]           g2g_ff, o1g_ff, o2g_ff;
   nrm_type [2:0]           o1h_ff, o2h_ff;
   logic signed [OP_W-1:0]  op_ff [9];
   logic signed [OFS_W-1:0] os_ff [3];
   logic signed [OFS_W-1:0] orr_in [3];
   fix_type [2:0]           ofs_in;
   lav_rsp_type             rsp_ff, rsp_in;

   // whole back part moves together; held while the result waits
   assign adv = !o3v_ff || rsp.ready;
   assign pop = q_vld && adv;

   // back axis
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n1_vec[i] = VEC_W'($signed(q_cmd.dlt[i]));
      end
      n1_side_in.eye = q_cmd.eye;
      n1_side_in.up  = q_cmd.up;
      n1_side_in.h   = '0;
   end

   lav_norm u_norm_back (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (q_vld),
      .in_vec   (n1_vec),
      .in_side  (n1_side_in),
      .out_vld  (n1_vld),
      .out_nrm  (n1_h),
      .out_side (n1_side)
   );

   // right axis from world up cross back
   lav_norm u_norm_right (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (cv_ff),
      .in_vec   (cv_vec_ff),
      .in_side  (cs_ff),
      .out_vld  (n2_vld),
      .out_nrm  (n2_f),
      .out_side (n2_side)
   );

   // camera up rounding and offset rounding with saturation
   always_comb begin
      gd_in[0] = GD_W'(gp_ff[0]) - GD_W'(gp_ff[1]) + G_RND;
      gd_in[1] = GD_W'(gp_ff[2]) - GD_W'(gp_ff[3]) + G_RND;
      gd_in[2] = GD_W'(gp_ff[4]) - GD_W'(gp_ff[5]) + G_RND;
      for (int r = 0; r < 3; r++) begin
         orr_in[r] = (os_ff[r] + O_RND) >>> FRAC_BITS;
         if (orr_in[r] > SAT_MAX) begin
            ofs_in[r] = SAT_MAX[31:0];
         end else if (orr_in[r] < SAT_MIN) begin
            ofs_in[r] = SAT_MIN[31:0];
         end else begin
            ofs_in[r] = orr_in[r][31:0];
         end
      end
      rsp_in.right_x          = 32'(o2f_ff[0]);
      rsp_in.right_y          = 32'(o2f_ff[1]);
      rsp_in.right_z          = 32'(o2f_ff[2]);
      rsp_in.right_offset     = ofs_in[0];
      rsp_in.camera_up_x      = 32'(o2g_ff[0]);
      rsp_in.camera_up_y      = 32'(o2g_ff[1]);
      rsp_in.camera_up_z      = 32'(o2g_ff[2]);
      rsp_in.camera_up_offset = ofs_in[1];
      rsp_in.back_x           = 32'(o2h_ff[0]);
      rsp_in.back_y           = 32'(o2h_ff[1]);
      rsp_in.back_z           = 32'(o2h_ff[2]);
      rsp_in.back_offset      = ofs_in[2];
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         xv_ff  <= 1'b0;
         cv_ff  <= 1'b0;
         g1v_ff <= 1'b0;
         g2v_ff <= 1'b0;
         o1v_ff <= 1'b0;
         o2v_ff <= 1'b0;
         o3v_ff <= 1'b0;
      end else if (adv) begin
         xv_ff  <= n1_vld;
         cv_ff  <= xv_ff;
         g1v_ff <= n2_vld;
         g2v_ff <= g1v_ff;
         o1v_ff <= g2v_ff;
         o2v_ff <= o1v_ff;
         o3v_ff <= o2v_ff;
      end
   end

   // arithmetic stages
   always_ff @(posedge clock) begin
      if (adv) begin
         // cross product terms
         xp_ff[0] <= $signed(n1_side.up[1]) * $signed(n1_h[2]);
         xp_ff[1] <= $signed(n1_side.up[2]) * $signed(n1_h[1]);
         xp_ff[2] <= $signed(n1_side.up[2]) * $signed(n1_h[0]);
         xp_ff[3] <= $signed(n1_side.up[0]) * $signed(n1_h[2]);
         xp_ff[4] <= $signed(n1_side.up[0]) * $signed(n1_h[1]);
         xp_ff[5] <= $signed(n1_side.up[1]) * $signed(n1_h[0]);
         xs_ff.eye <= n1_side.eye;
         xs_ff.up  <= n1_side.up;
         xs_ff.h   <= n1_h;
         // cross product differences
         cv_vec_ff[0] <= VEC_W'(xp_ff[0]) - VEC_W'(xp_ff[1]);
         cv_vec_ff[1] <= VEC_W'(xp_ff[2]) - VEC_W'(xp_ff[3]);
         cv_vec_ff[2] <= VEC_W'(xp_ff[4]) - VEC_W'(xp_ff[5]);
         cs_ff <= xs_ff;
         // camera up terms
         gp_ff[0] <= $signed(n2_side.h[1]) * $signed(n2_f[2]);
         gp_ff[1] <= $signed(n2_side.h[2]) * $signed(n2_f[1]);
         gp_ff[2] <= $signed(n2_side.h[2]) * $signed(n2_f[0]);
         gp_ff[3] <= $signed(n2_side.h[0]) * $signed(n2_f[2]);
         gp_ff[4] <= $signed(n2_side.h[0]) * $signed(n2_f[1]);
         gp_ff[5] <= $signed(n2_side.h[1]) * $signed(n2_f[0]);
         g1f_ff <= n2_f;
         g1s_ff <= n2_side;
         // camera up rounded
         for (int i = 0; i < 3; i++) begin
            g2g_ff[i] <= G_W'(gd_in[i] >>> FRAC_BITS);
         end
         g2f_ff <= g1f_ff;
         g2s_ff <= g1s_ff;
         // offset terms, rows right, camera up, back
         for (int i = 0; i < 3; i++) begin
            op_ff[i]     <= $signed(g2f_ff[i]) * $signed(g2s_ff.eye[i]);
            op_ff[3 + i] <= $signed(g2g_ff[i]) * $signed(g2s_ff.eye[i]);
            op_ff[6 + i] <= $signed(g2s_ff.h[i]) * $signed(g2s_ff.eye[i]);
         end
         o1f_ff <= g2f_ff;
         o1g_ff <= g2g_ff;
         o1h_ff <= g2s_ff.h;
         // negated dot products
         for (int r = 0; r < 3; r++) begin
            os_ff[r] <= -(OFS_W'(op_ff[3*r]) + OFS_W'(op_ff[3*r + 1]) + OFS_W'(op_ff[3*r + 2]));
         end
         o2f_ff <= o1f_ff;
         o2g_ff <= o1g_ff;
         o2h_ff <= o1h_ff;
         // result register
         rsp_ff <= rsp_in;
      end
   end

   assign rsp.valid = o3v_ff;
   assign rsp.data  = rsp_ff;

endmodule
`default_nettype wire

FILE: rtl/look_at_view_matrix_unit.sv
// Top level of the look-at view matrix unit.
`default_nettype none
`include "look_at_view_matrix_unit_defines.svh"
// Right-handed look-at view matrix in signed Q16.16: from an eye, a target and a world up
// vector it returns the upper three rows (right, camera up, back, each with its offset).
// One item is accepted per clock cycle and one result leaves per cycle while the response
// side is ready. From accept to result an item passes one front stage, the four-entry
// queue, then two pipelined normalizers of FRAC_BITS + 40 stages each (a 32-step square
// root and a FRAC_BITS + 1 step divide dominate; FRAC_BITS is 16 for Q16.16), plus seven
// product and rounding stages. When the result is not taken the back pipeline holds in
// place; the queue and front stage keep taking items until full.
module look_at_view_matrix_unit import lav_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   lav_req_if.sink   req_ch,
   lav_rsp_if.source rsp_ch
);

   logic          push_vld, push_rdy;
   lav_cmd_type   push_cmd;
   lav_cmd_type   q_cmd;
   lav_qstat_type q_stat;
   logic          pop;

   lav_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_ch),
      .push_vld (push_vld),
      .push_rdy (push_rdy),
      .push_cmd (push_cmd)
   );

   lav_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push_vld (push_vld),
      .push_rdy (push_rdy),
      .push_cmd (push_cmd),
      .pop      (pop),
      .stat     (q_stat),
      .pop_cmd  (q_cmd)
   );

   lav_back u_back (
      .clock (clock),
      .reset (reset),
      .q_vld (q_stat.vld),
      .q_cmd (q_cmd),
      .pop   (pop),
      .rsp   (rsp_ch)
   );

   // checks
   `LAV_ASSERT_NXT(a_front_holds, clock, reset, req_ch.valid && req_ch.ready, push_vld, "accepted item not held in front stage")
   `LAV_ASSERT_IMP(a_queue_bound, clock, reset, 1'b1, q_stat.count <= QCNT_W'(QDEPTH), "queue count beyond depth")
   `LAV_ASSERT_NXT(a_queue_stays_empty, clock, reset, (q_stat.count == '0) && !(push_vld && push_rdy), !q_stat.vld, "queue shows an item never pushed")

endmodule
`default_nettype wire
